// File: hdl/mpwm_pkg.sv
// shared types, constants and helpers for the multichannel pwm peripheral
package mpwm_pkg;

    localparam int CHANNELS = 4;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DATA_W = 32;

    // bits of a channel control word
    localparam int CTRL_EN_BIT  = 0;
    localparam int CTRL_POL_BIT = 1;
    localparam int CTRL_IE_BIT  = 2;

    // the global status word carries the enable flags from this bit up
    localparam int GLOBAL_EN_SHIFT = 8;

    // remainder by the period: one restoring step per bit of a 33 bit sum
    localparam int DIV_STEPS = DATA_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [1:0] KIND_READ    = 2'd0;
    localparam logic [1:0] KIND_WRITE   = 2'd1;
    localparam logic [1:0] KIND_ADVANCE = 2'd2;

    localparam logic [2:0] REG_GLOBAL  = 3'd0;
    localparam logic [2:0] REG_CONTROL = 3'd1;
    localparam logic [2:0] REG_PERIOD  = 3'd2;
    localparam logic [2:0] REG_DUTY    = 3'd3;
    localparam logic [2:0] REG_COUNTER = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_FINISH
    } mpwm_state_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [1:0]        channel;
        logic [2:0]        register_select;
        logic [DATA_W-1:0] write_value;
        logic [DATA_W-1:0] elapsed_ticks;
    } mpwm_in_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_level;
        logic [3:0]        pwm_levels;
        logic [3:0]        done_vector;
        logic [3:0]        enable_vector;
    } mpwm_out_t;

    // bus channel number to an index into the channel arrays
    function automatic logic [CH_IDX_W-1:0] ch_index(input logic [1:0] c);
        logic [3:0] wide;
        wide = {2'b00, c};
        return wide[CH_IDX_W-1:0];
    endfunction

    function automatic logic ch_present(input logic [1:0] c);
        return 32'(c) < 32'(CHANNELS);
    endfunction

endpackage

// File: hdl/multichannel_pwm_peripheral.sv
// multichannel pwm peripheral: register access and time advance engine
//
//  channel | ports                          | payload
//  --------+--------------------------------+---------------------------
//  input   | s_valid, s_ready, s_data       | mpwm_pkg::mpwm_in_t
//  result  | m_valid, m_ready, m_data       | mpwm_pkg::mpwm_out_t
//
// reads, writes and unused kinds go from idle straight to the finish step.
// an advance scans the channels in turn; for each channel whose sum
// reaches its period the remainder comes from one shared restoring
// subtractor that retires one bit per cycle.
// s_ready is high only while the sequencer is idle; one item is in work.
// aresetn clears all channel registers and flags at once, no clearing pass.
// a result held by m_ready low stalls only the finish step of the next item.
module multichannel_pwm_peripheral (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mpwm_pkg::mpwm_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mpwm_pkg::mpwm_out_t m_data
);

    localparam int N  = mpwm_pkg::CHANNELS;
    localparam int W  = mpwm_pkg::DATA_W;
    localparam int IW = mpwm_pkg::CH_IDX_W;
    localparam int CW = mpwm_pkg::DIV_CNT_W;

    mpwm_pkg::mpwm_state_t state_reg, state_next;

    logic [W-1:0] ctrl_reg   [N];
    logic [W-1:0] period_reg [N];
    logic [W-1:0] duty_reg   [N];
    logic [W-1:0] cnt_reg    [N];
    logic [N-1:0] done_reg;
    logic [N-1:0] en_reg;

    logic [IW-1:0] ch_idx_reg;
    logic [W-1:0]  ticks_reg;
    logic [W-1:0]  rd_reg;
    logic [W:0]    dvd_reg;
    logic [W:0]    rem_reg;
    logic [CW-1:0] step_reg;

    mpwm_pkg::mpwm_out_t out_reg;
    logic                out_valid_reg;

    logic          accept;
    logic          out_free;
    logic          load_out;
    logic [IW-1:0] addr;
    logic          addr_ok;
    logic [W-1:0]  ctrl_rd, period_rd, duty_rd, cnt_rd;
    logic [W-1:0]  read_value;
    logic [W:0]    total;
    logic          active;
    logic          wraps;
    logic [W:0]    rem_shift;
    logic [W:0]    rem_new;
    logic          last_ch;
    logic          div_last;
    logic [N-1:0]  pwm_vec;
    logic [N-1:0]  irq_vec;
    logic [7:0]    pwm_pad, done_pad, en_pad;

    // one signal-chosen port per channel array: bus channel while idle,
    // scan index while advancing
    assign addr    = (state_reg == mpwm_pkg::ST_IDLE) ?
                     mpwm_pkg::ch_index(s_data.channel) : ch_idx_reg;
    assign addr_ok = mpwm_pkg::ch_present(s_data.channel);
    assign ctrl_rd   = ctrl_reg[addr];
    assign period_rd = period_reg[addr];
    assign duty_rd   = duty_reg[addr];
    assign cnt_rd    = cnt_reg[addr];

    always_comb begin
        read_value = '0;
        case (s_data.register_select)
            mpwm_pkg::REG_GLOBAL: begin
                read_value = W'(done_reg) | (W'(en_reg) << mpwm_pkg::GLOBAL_EN_SHIFT);
            end
            mpwm_pkg::REG_CONTROL: read_value = addr_ok ? ctrl_rd : '0;
            mpwm_pkg::REG_PERIOD:  read_value = addr_ok ? period_rd : '0;
            mpwm_pkg::REG_DUTY:    read_value = addr_ok ? duty_rd : '0;
            mpwm_pkg::REG_COUNTER: read_value = addr_ok ? cnt_rd : '0;
            default:               read_value = '0;
        endcase
    end

    // shared datapath: one wide add/compare for the scan, one subtractor for the remainder
    assign total     = {1'b0, cnt_rd} + {1'b0, ticks_reg};
    assign active    = ctrl_rd[mpwm_pkg::CTRL_EN_BIT] && (period_rd != '0);
    assign wraps     = total >= {1'b0, period_rd};
    assign rem_shift = {rem_reg[W-1:0], dvd_reg[W]};
    assign rem_new   = (rem_shift >= {1'b0, period_rd}) ?
                       (rem_shift - {1'b0, period_rd}) : rem_shift;
    assign last_ch   = ch_idx_reg == IW'(N - 1);
    assign div_last  = step_reg == CW'(mpwm_pkg::DIV_STEPS - 1);

    always_comb begin
        for (int i = 0; i < N; i++) begin
            if (ctrl_reg[i][mpwm_pkg::CTRL_EN_BIT]) begin
                pwm_vec[i] = (cnt_reg[i] < duty_reg[i]) ^ ctrl_reg[i][mpwm_pkg::CTRL_POL_BIT];
            end else begin
                pwm_vec[i] = ctrl_reg[i][mpwm_pkg::CTRL_POL_BIT];
            end
            irq_vec[i] = done_reg[i] && ctrl_reg[i][mpwm_pkg::CTRL_IE_BIT];
        end
    end

    // only channels 0 to 3 reach the vectors
    assign pwm_pad  = 8'(pwm_vec);
    assign done_pad = 8'(done_reg);
    assign en_pad   = 8'(en_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mpwm_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = (s_data.kind == mpwm_pkg::KIND_ADVANCE) ?
                                 mpwm_pkg::ST_SCAN : mpwm_pkg::ST_FINISH;
                end
            end
            mpwm_pkg::ST_SCAN: begin
                if (active && wraps) begin
                    state_next = mpwm_pkg::ST_DIV;
                end else if (last_ch) begin
                    state_next = mpwm_pkg::ST_FINISH;
                end
            end
            mpwm_pkg::ST_DIV: begin
                if (div_last) begin
                    state_next = last_ch ? mpwm_pkg::ST_FINISH : mpwm_pkg::ST_SCAN;
                end
            end
            mpwm_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = mpwm_pkg::ST_IDLE;
                end
            end
            default: state_next = mpwm_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready  = state_reg == mpwm_pkg::ST_IDLE;
        out_free = !out_valid_reg || m_ready;
        load_out = (state_reg == mpwm_pkg::ST_FINISH) && out_free;
    end

    assign accept  = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mpwm_pkg::ST_IDLE;
            done_reg      <= '0;
            en_reg        <= '0;
            ch_idx_reg    <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < N; i++) begin
                ctrl_reg[i]   <= '0;
                period_reg[i] <= '0;
                duty_reg[i]   <= '0;
                cnt_reg[i]    <= '0;
            end
        end else begin
            state_reg <= state_next;

            if (accept) begin
                ticks_reg  <= s_data.elapsed_ticks;
                ch_idx_reg <= '0;
                rd_reg     <= (s_data.kind == mpwm_pkg::KIND_READ) ? read_value : '0;
                if (s_data.kind == mpwm_pkg::KIND_WRITE) begin
                    if (s_data.register_select == mpwm_pkg::REG_GLOBAL) begin
                        done_reg <= done_reg & ~s_data.write_value[N-1:0];
                    end else if (addr_ok && (s_data.register_select inside
                                 {[mpwm_pkg::REG_CONTROL:mpwm_pkg::REG_COUNTER]})) begin
                        case (s_data.register_select)
                            mpwm_pkg::REG_CONTROL: ctrl_reg[addr] <= s_data.write_value;
                            mpwm_pkg::REG_PERIOD: begin
                                period_reg[addr] <= s_data.write_value;
                                if (s_data.write_value == '0) begin
                                    cnt_reg[addr] <= '0;
                                end
                            end
                            mpwm_pkg::REG_DUTY: duty_reg[addr] <= s_data.write_value;
                            default: ;
                        endcase
                        // any channel write refreshes the mirrored enable flag
                        en_reg[addr] <= (s_data.register_select == mpwm_pkg::REG_CONTROL) ?
                                        s_data.write_value[mpwm_pkg::CTRL_EN_BIT] :
                                        ctrl_rd[mpwm_pkg::CTRL_EN_BIT];
                    end
                end
            end

            if (state_reg == mpwm_pkg::ST_SCAN) begin
                if (active && wraps) begin
                    done_reg[ch_idx_reg] <= 1'b1;
                    dvd_reg  <= total;
                    rem_reg  <= '0;
                    step_reg <= '0;
                end else begin
                    if (active) begin
                        cnt_reg[ch_idx_reg] <= total[W-1:0];
                    end
                    if (!last_ch) begin
                        ch_idx_reg <= ch_idx_reg + 1'b1;
                    end
                end
            end

            if (state_reg == mpwm_pkg::ST_DIV) begin
                rem_reg  <= rem_new;
                dvd_reg  <= {dvd_reg[W-1:0], 1'b0};
                step_reg <= step_reg + 1'b1;
                if (div_last) begin
                    cnt_reg[ch_idx_reg] <= rem_new[W-1:0];
                    if (!last_ch) begin
                        ch_idx_reg <= ch_idx_reg + 1'b1;
                    end
                end
            end

            if (load_out) begin
                out_valid_reg         <= 1'b1;
                out_reg.read_data     <= rd_reg;
                out_reg.irq_level     <= |irq_vec;
                out_reg.pwm_levels    <= pwm_pad[3:0];
                out_reg.done_vector   <= done_pad[3:0];
                out_reg.enable_vector <= en_pad[3:0];
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: hdl/mpwm_checker.sv
// port level checks for the multichannel pwm peripheral, bound to the top level
module mpwm_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input mpwm_pkg::mpwm_in_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input mpwm_pkg::mpwm_out_t m_data
);

    // a held result stays put
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // reset empties the output register
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // the engine is not ready in the cycle after taking an item
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item taken while previous one still in work");

    // irq needs a done flag among the visible channels
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.irq_level |->
            (mpwm_pkg::CHANNELS > 4) || (m_data.done_vector != 4'd0))
        else $error("irq without any done flag");

    // a result never rises directly behind an accept: the finish state lies between them
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_valid && s_ready))
        else $error("result appeared one cycle after accept");

endmodule

bind multichannel_pwm_peripheral mpwm_checker u_mpwm_checker (.*);
